@@ hw/rtl/hsv_to_rgb_converter_unit_macros.svh @@
// Assertion macros for the HSV to RGB converter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset
`define HSV2RGB_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("hsv2rgb: check failed");

// Check that an antecedent implies a consequent in the same cycle
`define HSV2RGB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv2rgb: implication failed");

`else

`define HSV2RGB_ASSERT_ALWAYS(label, clk, rst, cond)
`define HSV2RGB_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/hsv2rgb_pkg.sv @@
// Package for the HSV to RGB converter: widths, fixed-point constants,
// payload structs and sector codes. No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Field widths
  localparam int COLOR_BITS = 8;
  localparam int HUE_BITS   = 10;

  // Angle constants
  localparam int FULL_DEG    = 360;
  localparam int SECTOR_DEG  = 60;
  localparam int NUM_SECTORS = 6;

  localparam int COLOR_MAX  = (1 << COLOR_BITS) - 1;
  localparam int WRAP_COUNT = ((1 << HUE_BITS) - 1) / FULL_DEG;
  localparam int DEG_W      = $clog2(FULL_DEG);
  localparam int SECTOR_W   = $clog2(NUM_SECTORS);
  localparam int FRAC_W     = $clog2(SECTOR_DEG);

  // Every level is v * num / DEN with DEN = 60 * M
  localparam int DEN      = SECTOR_DEG * COLOR_MAX;
  localparam int NUM_W    = $clog2(DEN + 1);
  localparam int SF_W     = COLOR_BITS + FRAC_W;
  localparam int PROD_W   = COLOR_BITS + NUM_W;

  // Exact floor division by DEN as a reciprocal multiply and shift
  localparam int RECIP_SHIFT = PROD_W + NUM_W;
  localparam int RECIP_W     = PROD_W + 2;
  localparam int SCALED_W    = PROD_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + longint'(DEN) - 64'd1) / longint'(DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  // 60-degree hue sectors
  typedef enum logic [SECTOR_W-1:0] {
    SECTOR_RED_YELLOW    = 3'd0,
    SECTOR_YELLOW_GREEN  = 3'd1,
    SECTOR_GREEN_CYAN    = 3'd2,
    SECTOR_CYAN_BLUE     = 3'd3,
    SECTOR_BLUE_MAGENTA  = 3'd4,
    SECTOR_MAGENTA_RED   = 3'd5
  } sector_t;

  // Request payload
  typedef struct packed {
    logic [HUE_BITS-1:0]   hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS-1:0] brightness;
  } hsv_t;

  // Result payload
  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } rgb_t;

endpackage

@@ hw/rtl/hsv_to_rgb_converter_unit.sv @@
// Throughput: one request per cycle; set by the six-stage pipeline with one
// shared enable, which holds every stage while a result waits on color_ready.
// Reset (rst, synchronous) clears the valid bits only; no clearing pass.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_unit_macros.svh.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsv_to_rgb_converter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  hsv2rgb_pkg::hsv_t  pixel,
  output logic               color_valid,
  input  logic               color_ready,
  output hsv2rgb_pkg::rgb_t  color
);

  localparam int CB = hsv2rgb_pkg::COLOR_BITS;
  localparam int HB = hsv2rgb_pkg::HUE_BITS;

  // Pipeline advances whenever the output register is empty or drained;
  // refuse requests while reset is held so none is dropped
  logic advance;
  assign advance     = !color_valid || color_ready;
  assign pixel_ready = advance && !rst;

  // Stage valid bits
  logic vld1, vld2, vld3, vld4, vld5;

  // Stage 1: reduce hue modulo 360
  logic [HB-1:0]                 hue_rem;
  logic [hsv2rgb_pkg::DEG_W-1:0] deg1;
  logic [CB-1:0]                 sat1, bri1;

  always_comb begin
    hue_rem = pixel.hue;
    for (int k = 1; k <= hsv2rgb_pkg::WRAP_COUNT; k++) begin
      if (pixel.hue >= HB'(k * hsv2rgb_pkg::FULL_DEG)) begin
        hue_rem = pixel.hue - HB'(k * hsv2rgb_pkg::FULL_DEG);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      deg1 <= hsv2rgb_pkg::DEG_W'(hue_rem);
      sat1 <= pixel.saturation;
      bri1 <= pixel.brightness;
    end
  end

  // Stage 2: split the angle into sector and fraction in 1/60 steps
  hsv2rgb_pkg::sector_t           sec_c, sec2;
  logic [hsv2rgb_pkg::FRAC_W-1:0] frac_c, frac2;
  logic [CB-1:0]                  sat2, bri2;

  always_comb begin
    sec_c  = hsv2rgb_pkg::SECTOR_RED_YELLOW;
    frac_c = hsv2rgb_pkg::FRAC_W'(deg1);
    for (int k = 1; k < hsv2rgb_pkg::NUM_SECTORS; k++) begin
      if (deg1 >= hsv2rgb_pkg::DEG_W'(k * hsv2rgb_pkg::SECTOR_DEG)) begin
        sec_c  = hsv2rgb_pkg::sector_t'(hsv2rgb_pkg::SECTOR_W'(k));
        frac_c = hsv2rgb_pkg::FRAC_W'(deg1 - hsv2rgb_pkg::DEG_W'(k * hsv2rgb_pkg::SECTOR_DEG));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sec2  <= sec_c;
      frac2 <= frac_c;
      sat2  <= sat1;
      bri2  <= bri1;
    end
  end

  // Stage 3: form s*f and the p numerator 60*(M - s)
  logic [hsv2rgb_pkg::SF_W-1:0]  sf3;
  logic [hsv2rgb_pkg::NUM_W-1:0] pnum3;
  hsv2rgb_pkg::sector_t          sec3;
  logic [CB-1:0]                 bri3;

  always_ff @(posedge clk) begin
    if (advance) begin
      sf3   <= hsv2rgb_pkg::SF_W'(sat2) * hsv2rgb_pkg::SF_W'(frac2);
      pnum3 <= hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SECTOR_DEG)
             * (hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::COLOR_MAX) - hsv2rgb_pkg::NUM_W'(sat2));
      sec3  <= sec2;
      bri3  <= bri2;
    end
  end

  // Stage 4: numerators for q and t, then scale all three by v
  logic [hsv2rgb_pkg::NUM_W-1:0]  qnum, tnum;
  logic [hsv2rgb_pkg::PROD_W-1:0] prod_p4, prod_q4, prod_t4;
  hsv2rgb_pkg::sector_t           sec4;
  logic [CB-1:0]                  bri4;

  assign qnum = hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::DEN) - hsv2rgb_pkg::NUM_W'(sf3);
  assign tnum = pnum3 + hsv2rgb_pkg::NUM_W'(sf3);

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_p4 <= hsv2rgb_pkg::PROD_W'(bri3) * hsv2rgb_pkg::PROD_W'(pnum3);
      prod_q4 <= hsv2rgb_pkg::PROD_W'(bri3) * hsv2rgb_pkg::PROD_W'(qnum);
      prod_t4 <= hsv2rgb_pkg::PROD_W'(bri3) * hsv2rgb_pkg::PROD_W'(tnum);
      sec4    <= sec3;
      bri4    <= bri3;
    end
  end

  // Stage 5: divide by 60*M, rounding down, via reciprocal multiply
  logic [hsv2rgb_pkg::SCALED_W-1:0] scaled_p, scaled_q, scaled_t;
  logic [CB-1:0]                    lvl_p5, lvl_q5, lvl_t5, bri5;
  hsv2rgb_pkg::sector_t             sec5;

  assign scaled_p = hsv2rgb_pkg::SCALED_W'(prod_p4) * hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::RECIP);
  assign scaled_q = hsv2rgb_pkg::SCALED_W'(prod_q4) * hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::RECIP);
  assign scaled_t = hsv2rgb_pkg::SCALED_W'(prod_t4) * hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (advance) begin
      lvl_p5 <= scaled_p[hsv2rgb_pkg::RECIP_SHIFT +: CB];
      lvl_q5 <= scaled_q[hsv2rgb_pkg::RECIP_SHIFT +: CB];
      lvl_t5 <= scaled_t[hsv2rgb_pkg::RECIP_SHIFT +: CB];
      sec5   <= sec4;
      bri5   <= bri4;
    end
  end

  // Stage 6: route levels by sector; zero saturation makes p, q and t equal v
  hsv2rgb_pkg::rgb_t color_next;

  always_comb begin
    unique case (sec5)
      hsv2rgb_pkg::SECTOR_RED_YELLOW:   color_next = '{bri5, lvl_t5, lvl_p5};
      hsv2rgb_pkg::SECTOR_YELLOW_GREEN: color_next = '{lvl_q5, bri5, lvl_p5};
      hsv2rgb_pkg::SECTOR_GREEN_CYAN:   color_next = '{lvl_p5, bri5, lvl_t5};
      hsv2rgb_pkg::SECTOR_CYAN_BLUE:    color_next = '{lvl_p5, lvl_q5, bri5};
      hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: color_next = '{lvl_t5, lvl_p5, bri5};
      default:                          color_next = '{bri5, lvl_p5, lvl_q5};
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      color <= color_next;
    end
  end

  // Advance valid bits with the data; hold them on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1        <= 1'b0;
      vld2        <= 1'b0;
      vld3        <= 1'b0;
      vld4        <= 1'b0;
      vld5        <= 1'b0;
      color_valid <= 1'b0;
    end else if (advance) begin
      vld1        <= pixel_valid;
      vld2        <= vld1;
      vld3        <= vld2;
      vld4        <= vld3;
      vld5        <= vld4;
      color_valid <= vld5;
    end
  end

  // Checks
  `HSV2RGB_ASSERT_IMPLIES(a_deg_wrapped, clk, rst, vld1,
    deg1 < hsv2rgb_pkg::DEG_W'(hsv2rgb_pkg::FULL_DEG))
  `HSV2RGB_ASSERT_IMPLIES(a_frac_in_sector, clk, rst, vld2,
    frac2 < hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::SECTOR_DEG))
  `HSV2RGB_ASSERT_IMPLIES(a_levels_below_value, clk, rst, vld5,
    (lvl_p5 <= bri5) && (lvl_q5 <= bri5) && (lvl_t5 <= bri5))
  `HSV2RGB_ASSERT_ALWAYS(a_result_from_stage5, clk, rst,
    !(color_valid && !$past(color_valid)) || $past(vld5))

endmodule

@@ tb/hsv_to_rgb_converter_unit_tb.sv @@
// Self-checking testbench for hsv_to_rgb_converter_unit: directed color table, then random
// requests, with random stalls on both handshakes. Depends on hsv2rgb_pkg and the RTL only.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit_tb;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_COUNT   = 1550;
  localparam int QUIET_FIRST    = 700;
  localparam int QUIET_LAST     = 1000;
  localparam int IDLE_PCT       = 35;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    hsv_t px;
    bit   typed;
    rgb_t rgb;
  } color_row_t;

  typedef struct {
    hsv_t px;
    rgb_t rgb;
  } pending_color_t;

  logic clk;
  logic rst;
  logic pixel_valid;
  logic pixel_ready;
  hsv_t pixel;
  logic color_valid;
  logic color_ready;
  rgb_t color;

  color_row_t     color_table [$];
  pending_color_t pending_colors [$];
  int             mismatch_count;
  int             stall_count;
  bit             no_idle;

  hsv_to_rgb_converter_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .color       (color)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Work out the RGB triple for one HSV request
  function automatic rgb_t hsv_to_rgb_expected(hsv_t px);
    int unsigned hue_deg;
    int unsigned sat;
    int unsigned val;
    int unsigned frac;
    int unsigned den;
    int unsigned lvl_p;
    int unsigned lvl_q;
    int unsigned lvl_t;
    sector_t     sec;
    rgb_t        c;
    sat = px.saturation;
    val = px.brightness;
    if (sat == 0) begin
      c = '{COLOR_BITS'(val), COLOR_BITS'(val), COLOR_BITS'(val)};
    end else begin
      hue_deg = px.hue % FULL_DEG;
      sec     = sector_t'(hue_deg / SECTOR_DEG);
      frac    = hue_deg % SECTOR_DEG;
      den     = SECTOR_DEG * COLOR_MAX;
      lvl_p   = val * (COLOR_MAX - sat) / COLOR_MAX;
      lvl_q   = val * (den - sat * frac) / den;
      lvl_t   = val * (den - sat * (SECTOR_DEG - frac)) / den;
      case (sec)
        SECTOR_RED_YELLOW: begin
          c = '{COLOR_BITS'(val), COLOR_BITS'(lvl_t), COLOR_BITS'(lvl_p)};
        end
        SECTOR_YELLOW_GREEN: begin
          c = '{COLOR_BITS'(lvl_q), COLOR_BITS'(val), COLOR_BITS'(lvl_p)};
        end
        SECTOR_GREEN_CYAN: begin
          c = '{COLOR_BITS'(lvl_p), COLOR_BITS'(val), COLOR_BITS'(lvl_t)};
        end
        SECTOR_CYAN_BLUE: begin
          c = '{COLOR_BITS'(lvl_p), COLOR_BITS'(lvl_q), COLOR_BITS'(val)};
        end
        SECTOR_BLUE_MAGENTA: begin
          c = '{COLOR_BITS'(lvl_t), COLOR_BITS'(lvl_p), COLOR_BITS'(val)};
        end
        default: begin
          c = '{COLOR_BITS'(val), COLOR_BITS'(lvl_p), COLOR_BITS'(lvl_q)};
        end
      endcase
    end
    return c;
  endfunction

  // Append one directed request; typed rows carry their expected color
  task automatic add_color_row(input int h, input int s, input int v, input bit typed,
                               input int r, input int g, input int b);
    color_row_t row;
    row.px    = '{HUE_BITS'(h), COLOR_BITS'(s), COLOR_BITS'(v)};
    row.typed = typed;
    row.rgb   = '{COLOR_BITS'(r), COLOR_BITS'(g), COLOR_BITS'(b)};
    color_table.push_back(row);
  endtask

  // Drive one request and hold it until accepted; valid stays high on return
  task automatic send_pixel(input hsv_t px, input bit typed, input rgb_t typed_rgb);
    pending_color_t exp;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    pixel       <= px;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    exp.px  = px;
    exp.rgb = typed ? typed_rgb : hsv_to_rgb_expected(px);
    pending_colors.push_back(exp);
  endtask

  // Bias color levels toward the ends of the range
  function automatic logic [COLOR_BITS-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return COLOR_BITS'(COLOR_MAX);
    return COLOR_BITS'($urandom_range(COLOR_MAX));
  endfunction

  // Mix full-range hues with hues at sector edges and around the wrap
  function automatic logic [HUE_BITS-1:0] pick_hue();
    if ($urandom_range(3) == 0) begin
      return HUE_BITS'($urandom_range(1, 17) * SECTOR_DEG - 1 + $urandom_range(2));
    end
    return HUE_BITS'($urandom_range((1 << HUE_BITS) - 1));
  endfunction

  // Stimulus
  initial begin
    hsv_t px;
    rgb_t none;
    none           = '0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    rst            <= 1'b1;
    pixel_valid    <= 1'b0;
    pixel          <= '0;

    // sector starts at full saturation and value
    add_color_row(0,    255, 255, 1, 255, 0,   0);
    add_color_row(60,   255, 255, 1, 255, 255, 0);
    add_color_row(120,  255, 255, 1, 0,   255, 0);
    add_color_row(180,  255, 255, 1, 0,   255, 255);
    add_color_row(240,  255, 255, 1, 0,   0,   255);
    add_color_row(300,  255, 255, 1, 255, 0,   255);
    // hue wrap at 360 and beyond
    add_color_row(360,  255, 255, 1, 255, 0,   0);
    add_color_row(720,  255, 255, 1, 255, 0,   0);
    add_color_row(359,  255, 255, 0, 0,   0,   0);
    add_color_row(361,  255, 255, 0, 0,   0,   0);
    add_color_row(719,  255, 255, 0, 0,   0,   0);
    add_color_row(1023, 255, 255, 0, 0,   0,   0);
    // zero saturation gives gray, zero value gives black
    add_color_row(77,   0,   200, 1, 200, 200, 200);
    add_color_row(1023, 0,   0,   1, 0,   0,   0);
    add_color_row(360,  0,   255, 1, 255, 255, 255);
    add_color_row(200,  255, 0,   1, 0,   0,   0);
    // mid-sector fractions in every sector
    add_color_row(30,   128, 200, 0, 0,   0,   0);
    add_color_row(90,   1,   255, 0, 0,   0,   0);
    add_color_row(150,  200, 100, 0, 0,   0,   0);
    add_color_row(210,  255, 17,  0, 0,   0,   0);
    add_color_row(270,  99,  254, 0, 0,   0,   0);
    add_color_row(330,  170, 85,  0, 0,   0,   0);
    add_color_row(59,   254, 1,   0, 0,   0,   0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (color_table[i]) begin
      send_pixel(color_table[i].px, color_table[i].typed, color_table[i].rgb);
    end

    // hold off new requests until the pipeline has drained
    pixel_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      no_idle       = (n >= QUIET_FIRST && n < QUIET_LAST);
      px.hue        = pick_hue();
      px.saturation = pick_level();
      px.brightness = pick_level();
      send_pixel(px, 1'b0, none);
    end
    no_idle = 1'b0;
    pixel_valid <= 1'b0;

    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Randomly stall the result side
  initial color_ready <= 1'b0;
  always @(posedge clk) begin
    color_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check each result against the oldest expected color
  always @(posedge clk) begin
    pending_color_t exp;
    if (!rst && color_valid && color_ready) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected color r=%0d g=%0d b=%0d", $time,
                 color.red, color.green, color.blue);
        mismatch_count++;
      end else begin
        exp = pending_colors.pop_front();
        if (color.red !== exp.rgb.red) begin
          $display("%0t: red mismatch hsv=(%0d,%0d,%0d) expected %0d actual %0d", $time,
                   exp.px.hue, exp.px.saturation, exp.px.brightness, exp.rgb.red, color.red);
          mismatch_count++;
        end
        if (color.green !== exp.rgb.green) begin
          $display("%0t: green mismatch hsv=(%0d,%0d,%0d) expected %0d actual %0d", $time,
                   exp.px.hue, exp.px.saturation, exp.px.brightness, exp.rgb.green,
                   color.green);
          mismatch_count++;
        end
        if (color.blue !== exp.rgb.blue) begin
          $display("%0t: blue mismatch hsv=(%0d,%0d,%0d) expected %0d actual %0d", $time,
                   exp.px.hue, exp.px.saturation, exp.px.brightness, exp.rgb.blue,
                   color.blue);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither handshake moves for too long
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (color_valid && color_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, stall_count);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv_to_rgb_converter_unit.sv
tb/hsv_to_rgb_converter_unit_tb.sv
